/* rtl/ucfd_pkg.sv */
// Shared types and constants for the serial-to-CAN frame deframer.
// Used by the channel interfaces, the frame parser and the top level.
package ucfd_pkg;

   localparam int MAX_PAYLOAD   = 8;     // payload bytes kept per frame, 0..8
   localparam int PAYLOAD_SLOTS = 8;     // payload fields on the result item
   localparam int SLOT_IDX_W    = 3;     // index into the payload slots
   localparam int ID_W          = 11;
   localparam int LEN_W         = 4;

   localparam logic [7:0] START_BYTE = 8'hFD;
   localparam logic [7:0] END_BYTE   = 8'hBF;
   localparam logic [7:0] LEN_MASK   = 8'hF0;
   localparam logic [7:0] IDHI_MASK  = 8'b00000111;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_HEADER = 3'd1,
      PH_IDLOW  = 3'd2,
      PH_DATA   = 3'd3,
      PH_END    = 3'd4
   } phase_type;

   typedef enum logic {
      STATUS_GOOD = 1'b0,
      STATUS_BAD  = 1'b1
   } status_type;

   typedef struct packed {
      logic                               frame_status;
      logic [ID_W-1:0]                    frame_id;
      logic [LEN_W-1:0]                   frame_len;
      logic [PAYLOAD_SLOTS-1:0][7:0]      payload;
   } frame_type;

endpackage

/* rtl/ucfd_if.sv */
// Valid/ready channel interfaces for the deframer: byte input and frame result.
// Depends on ucfd_pkg for field widths.
interface ucfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           frame_status;
   logic [ucfd_pkg::ID_W-1:0]      frame_id;
   logic [ucfd_pkg::LEN_W-1:0]     frame_len;
   logic [7:0]                     payload_0;
   logic [7:0]                     payload_1;
   logic [7:0]                     payload_2;
   logic [7:0]                     payload_3;
   logic [7:0]                     payload_4;
   logic [7:0]                     payload_5;
   logic [7:0]                     payload_6;
   logic [7:0]                     payload_7;

   modport source (output valid, output frame_status, output frame_id, output frame_len,
                   output payload_0, output payload_1, output payload_2, output payload_3,
                   output payload_4, output payload_5, output payload_6, output payload_7,
                   input ready);
   modport sink   (input valid, input frame_status, input frame_id, input frame_len,
                   input payload_0, input payload_1, input payload_2, input payload_3,
                   input payload_4, input payload_5, input payload_6, input payload_7,
                   output ready);
endinterface

/* rtl/ucfd_parser.sv */
// Frame parser: walks the start/header/id/payload/end byte sequence, one byte per step.
// Depends on ucfd_pkg for the phase enum, byte codes and the frame struct.
module ucfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   output logic                 emit,
   output ucfd_pkg::frame_type  frame
);

   ucfd_pkg::phase_type                  phase_ff, phase_in;
   logic [ucfd_pkg::LEN_W-1:0]           count_ff;
   logic [ucfd_pkg::ID_W-1:0]            id_ff;
   logic [ucfd_pkg::LEN_W-1:0]           len_ff;
   logic [ucfd_pkg::PAYLOAD_SLOTS-1:0][7:0] payload_ff;

   logic [ucfd_pkg::LEN_W-1:0] hdr_len;
   logic [ucfd_pkg::LEN_W-1:0] clamped_len;
   logic [ucfd_pkg::LEN_W-1:0] count_next;

   assign hdr_len     = ucfd_pkg::LEN_W'((rx_byte & ucfd_pkg::LEN_MASK) >> 4);
   assign clamped_len = (hdr_len > ucfd_pkg::MAX_LEN) ? ucfd_pkg::MAX_LEN : hdr_len;
   assign count_next  = count_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         ucfd_pkg::PH_HUNT: begin
            if (step && rx_byte == ucfd_pkg::START_BYTE) phase_in = ucfd_pkg::PH_HEADER;
         end
         ucfd_pkg::PH_HEADER: begin
            if (step) phase_in = ucfd_pkg::PH_IDLOW;
         end
         ucfd_pkg::PH_IDLOW: begin
            if (step) phase_in = (len_ff == '0) ? ucfd_pkg::PH_END : ucfd_pkg::PH_DATA;
         end
         ucfd_pkg::PH_DATA: begin
            if (step && count_next >= len_ff) phase_in = ucfd_pkg::PH_END;
         end
         ucfd_pkg::PH_END: begin
            if (step) phase_in = ucfd_pkg::PH_HUNT;
         end
         default: begin
            // unused codes behave as hunting
            if (step && rx_byte == ucfd_pkg::START_BYTE) phase_in = ucfd_pkg::PH_HEADER;
         end
      endcase
   end

   // result for the end byte; slots at or above the length read as zero
   always_comb begin
      emit               = step && (phase_ff == ucfd_pkg::PH_END);
      frame.frame_status = (rx_byte == ucfd_pkg::END_BYTE) ? ucfd_pkg::STATUS_GOOD
                                                            : ucfd_pkg::STATUS_BAD;
      frame.frame_id     = id_ff;
      frame.frame_len    = len_ff;
      for (int k = 0; k < ucfd_pkg::PAYLOAD_SLOTS; k++) begin
         frame.payload[k] = (ucfd_pkg::LEN_W'(k) < len_ff) ? payload_ff[k] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ucfd_pkg::PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         unique case (phase_ff)
            ucfd_pkg::PH_HEADER: begin
               len_ff <= clamped_len;
               id_ff  <= {rx_byte[2:0] & ucfd_pkg::IDHI_MASK[2:0], 8'h00};
            end
            ucfd_pkg::PH_IDLOW: begin
               id_ff    <= {id_ff[ucfd_pkg::ID_W-1:8], rx_byte};
               count_ff <= '0;
            end
            ucfd_pkg::PH_DATA: begin
               payload_ff[count_ff[ucfd_pkg::SLOT_IDX_W-1:0]] <= rx_byte;
               count_ff <= count_next;
            end
            default: begin
               // hold
            end
         endcase
      end
   end

endmodule

/* rtl/uart_can_frame_deframer_top.sv */
// Serial byte stream to CAN-style frame deframer, top level.
// Result: a frame item is registered and appears in the cycle after its end byte is accepted.
// Throughput: one byte accepted every cycle; the result register frees in the
// cycle its item is taken, so the input stalls only while a result waits.
// Reset: synchronous, active high; hunts for a start byte, no result pending.
// Depends on ucfd_pkg, ucfd_if (channel interfaces) and ucfd_parser.
module uart_can_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   ucfd_req_if.sink    req_ch,
   ucfd_rsp_if.source  rsp_ch
);

   logic                rsp_valid_ff;
   ucfd_pkg::frame_type rsp_frame_ff;

   logic                step;
   logic                emit;
   ucfd_pkg::frame_type frame;

   // take a byte whenever the result register is empty or being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign step         = req_ch.valid && req_ch.ready;

   ucfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_ch.rx_byte),
      .emit    (emit),
      .frame   (frame)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_frame_ff <= frame;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_status = rsp_frame_ff.frame_status;
   assign rsp_ch.frame_id     = rsp_frame_ff.frame_id;
   assign rsp_ch.frame_len    = rsp_frame_ff.frame_len;
   assign rsp_ch.payload_0    = rsp_frame_ff.payload[0];
   assign rsp_ch.payload_1    = rsp_frame_ff.payload[1];
   assign rsp_ch.payload_2    = rsp_frame_ff.payload[2];
   assign rsp_ch.payload_3    = rsp_frame_ff.payload[3];
   assign rsp_ch.payload_4    = rsp_frame_ff.payload[4];
   assign rsp_ch.payload_5    = rsp_frame_ff.payload[5];
   assign rsp_ch.payload_6    = rsp_frame_ff.payload[6];
   assign rsp_ch.payload_7    = rsp_frame_ff.payload[7];

endmodule
